### rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Command codes and field widths shared by the frame buffer drawing engine.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 8;
    localparam int CMD_W   = 3;

    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COLOR_W-1:0]        t_color;

    localparam t_cmd CMD_PIXEL   = 3'd0;
    localparam t_cmd CMD_HLINE   = 3'd1;
    localparam t_cmd CMD_VLINE   = 3'd2;
    localparam t_cmd CMD_FILL    = 3'd3;
    localparam t_cmd CMD_OUTLINE = 3'd4;
    localparam t_cmd CMD_CLEAR   = 3'd5;
    localparam t_cmd CMD_READ    = 3'd6;

endpackage

### rtl/cfd_ram.sv
// ----------------------------------------------------------------------------
// cfd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/clipped_framebuffer_draw.sv
// ----------------------------------------------------------------------------
// clipped_framebuffer_draw
// Byte-per-pixel frame buffer with clipped pixel, line, rectangle, outline,
// clear and read-back commands.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one command per transfer.
// Output channel: o_out_valid / i_out_stall carry one result per command.
// Drawing commands return an all-zero result, loaded into the output
// register at the input transfer; a read returns the pixel through the
// address state, the memory's read register and the output register.
// Commands run one at a time. A drawing command clips each of its parts
// (one part, four for an outline), forms the start address of each
// non-empty part and then writes one clipped pixel per cycle, since the
// frame memory has a single write port. Clear fills the whole screen as
// one part. A new command is taken once the previous one is done and the
// output register is empty or being emptied.
// After reset a clearing pass writes zero to all SCREEN_WIDTH*SCREEN_HEIGHT
// entries, one per cycle, while o_in_stall stays high.
// A stalled result is held in the output register until it is taken.
// ----------------------------------------------------------------------------
module clipped_framebuffer_draw #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cfd_pkg::t_cmd   i_command,
    input  cfd_pkg::t_coord i_pos_x,
    input  cfd_pkg::t_coord i_pos_y,
    input  cfd_pkg::t_coord i_size_w,
    input  cfd_pkg::t_coord i_size_h,
    input  cfd_pkg::t_color i_color,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cfd_pkg::t_color o_read_color,
    output logic            o_read_valid
);
    import cfd_pkg::*;

    localparam int N_PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (N_PIX > 1) ? $clog2(N_PIX) : 1;
    localparam int XB    = $clog2(SCREEN_WIDTH + 1);
    localparam int YB    = $clog2(SCREEN_HEIGHT + 1);
    localparam int EW    = COORD_W + 2;

    localparam logic [AW-1:0]        W_A    = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0]        LAST_A = AW'(N_PIX - 1);
    localparam logic signed [EW-1:0] W_S    = EW'(SCREEN_WIDTH);
    localparam logic signed [EW-1:0] H_S    = EW'(SCREEN_HEIGHT);
    localparam logic signed [EW-1:0] ONE_S  = EW'(1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLIP  = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_RADDR = 3'd5;
    localparam logic [2:0] S_RDATA = 3'd6;

    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd;
    t_coord        r_x, r_y, r_w, r_h;
    t_color        r_color;
    logic [1:0]    r_part, r_last;
    logic [XB-1:0] r_x0, r_x1, r_cx;
    logic [YB-1:0] r_y0, r_y1, r_cy;
    logic [AW-1:0] r_addr, r_row;
    logic          r_on;
    logic          r_out_valid;
    t_color        r_out_color;
    logic          r_out_rvalid;

    logic                 in_xfer, out_xfer;
    logic signed [EW-1:0] xe, ye, we_s, he_s;
    logic signed [EW-1:0] bx0, by0, bx1, by1;
    logic signed [EW-1:0] cx0, cy0, cx1, cy1;
    logic                 part_empty;
    logic                 col_end, row_end;
    logic                 on_screen;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    t_color               mem_wdata, mem_rdata;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // raw part bounds, half-open
    assign xe   = EW'(r_x);
    assign ye   = EW'(r_y);
    assign we_s = EW'(r_w);
    assign he_s = EW'(r_h);

    always_comb begin
        bx0 = xe;
        by0 = ye;
        bx1 = xe + ONE_S;
        by1 = ye + ONE_S;
        unique case (r_cmd)
            CMD_PIXEL: begin
            end
            CMD_HLINE: begin
                bx1 = xe + we_s;
            end
            CMD_VLINE: begin
                by1 = ye + he_s;
            end
            CMD_FILL: begin
                bx1 = xe + we_s;
                by1 = ye + he_s;
            end
            CMD_OUTLINE: begin
                unique case (r_part)
                    2'd0: begin
                        bx1 = xe + we_s;
                    end
                    2'd1: begin
                        by0 = ye + he_s - ONE_S;
                        bx1 = xe + we_s;
                        by1 = ye + he_s;
                    end
                    2'd2: begin
                        by1 = ye + he_s;
                    end
                    default: begin
                        bx0 = xe + we_s - ONE_S;
                        bx1 = xe + we_s;
                        by1 = ye + he_s;
                    end
                endcase
            end
            default: begin
                bx0 = '0;
                by0 = '0;
                bx1 = W_S;
                by1 = H_S;
            end
        endcase
    end

    assign cx0        = (bx0 < 0) ? '0 : bx0;
    assign cy0        = (by0 < 0) ? '0 : by0;
    assign cx1        = (bx1 > W_S) ? W_S : bx1;
    assign cy1        = (by1 > H_S) ? H_S : by1;
    assign part_empty = (cx0 >= cx1) || (cy0 >= cy1);

    assign col_end = (r_cx + XB'(1)) == r_x1;
    assign row_end = (r_cy + YB'(1)) == r_y1;

    assign on_screen = (xe >= 0) && (xe < W_S) && (ye >= 0) && (ye < H_S);
    assign rd_addr   = AW'(r_y[YB-1:0]) * W_A + AW'(r_x[XB-1:0]);

    assign mem_we    = (r_state == S_INIT) || (r_state == S_FILL);
    assign mem_wdata = (r_state == S_INIT) ? '0 : r_color;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_addr == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_command == CMD_READ) begin
                        n_state = S_RADDR;
                    end else if (i_command <= CMD_CLEAR) begin
                        n_state = S_CLIP;
                    end
                end
            end
            S_CLIP: begin
                if (!part_empty) begin
                    n_state = S_BASE;
                end else if (r_part == r_last) begin
                    n_state = S_IDLE;
                end
            end
            S_BASE: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                if (col_end && row_end) begin
                    n_state = (r_part == r_last) ? S_IDLE : S_CLIP;
                end
            end
            S_RADDR: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_xfer) begin
                r_cmd   <= i_command;
                r_x     <= i_pos_x;
                r_y     <= i_pos_y;
                r_w     <= i_size_w;
                r_h     <= i_size_h;
                r_color <= i_color;
                r_part  <= 2'd0;
                r_last  <= (i_command == CMD_OUTLINE) ? 2'd3 : 2'd0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + AW'(1);
                end
                S_CLIP: begin
                    r_x0 <= XB'(cx0);
                    r_y0 <= YB'(cy0);
                    r_x1 <= XB'(cx1);
                    r_y1 <= YB'(cy1);
                    if (part_empty && (r_part != r_last)) begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_BASE: begin
                    r_row  <= AW'(r_y0) * W_A;
                    r_addr <= AW'(r_y0) * W_A + AW'(r_x0);
                    r_cx   <= r_x0;
                    r_cy   <= r_y0;
                end
                S_FILL: begin
                    if (!col_end) begin
                        r_cx   <= r_cx + XB'(1);
                        r_addr <= r_addr + AW'(1);
                    end else if (!row_end) begin
                        r_cx   <= r_x0;
                        r_cy   <= r_cy + YB'(1);
                        r_row  <= r_row + W_A;
                        r_addr <= r_row + W_A + AW'(r_x0);
                    end else if (r_part != r_last) begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_RADDR: begin
                    r_on <= on_screen;
                end
                default: begin
                end
            endcase

            // output register
            if (r_state == S_RDATA) begin
                r_out_valid  <= 1'b1;
                r_out_color  <= r_on ? mem_rdata : '0;
                r_out_rvalid <= r_on;
            end else if (in_xfer && (i_command != CMD_READ)) begin
                r_out_valid  <= 1'b1;
                r_out_color  <= '0;
                r_out_rvalid <= 1'b0;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    cfd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (N_PIX)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_color = r_out_color;
    assign o_read_valid = r_out_rvalid;

endmodule

### rtl/cfd_check.sv
// ----------------------------------------------------------------------------
// cfd_check
// Port-level checks for the frame buffer drawing engine, bound to its top.
// ----------------------------------------------------------------------------
module cfd_check (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input cfd_pkg::t_cmd   i_command,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input cfd_pkg::t_color o_read_color,
    input logic            o_read_valid
);
    import cfd_pkg::*;

    // stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_read_color) && $stable(o_read_valid))
        else $error("stalled result changed");

    // off-screen or non-read result carries no color
    a_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_color == '0)
        else $error("color set without read_valid");

    // drawing commands answer in the next cycle
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command != CMD_READ) |=>
            o_out_valid && !o_read_valid)
        else $error("missing result for drawing command");

    // a read transfer is followed by a busy input side
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_READ) |=> o_in_stall)
        else $error("input taken during read");

endmodule

bind clipped_framebuffer_draw cfd_check u_cfd_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_command    (i_command),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_color (o_read_color),
    .o_read_valid (o_read_valid)
);
